// File: rtl/base64_stream_encoder_assert.svh
// assertion macros for the base64 stream encoder
// expects clk and rst_n in the scope of each use
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define B64_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define B64_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define B64_ASSERT_SAME(label, ante, cons)
`define B64_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/b64enc_pkg.sv
// shared types, constants and the sextet-to-character lookup
// used by every module of the base64 stream encoder
package b64enc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            fin;
  } b64enc_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64enc_qstat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// File: rtl/b64enc_in_if.sv
// input channel: one raw byte per transfer with a final flag
// depends on nothing
interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, data_byte, is_final, input ready);
  modport sink (input valid, data_byte, is_final, output ready);
endinterface

// File: rtl/b64enc_out_if.sv
// result channel: one base64 character per transfer with run and message marks
// depends on nothing
interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_run;
  logic       end_of_message;

  modport source (output valid, out_char, end_of_run, end_of_message, input ready);
  modport sink (input valid, out_char, end_of_run, end_of_message, output ready);
endinterface

// File: rtl/base64_stream_encoder.sv
// top level of the base64 stream encoder: front end, command queue, back end
// depends on b64enc_pkg, b64enc_in_if, b64enc_out_if and the assertion macros
//
// Encodes a byte stream into standard-alphabet base64 with '=' padding. Each
// input byte yields one to four characters, one per cycle on the result
// channel while the receiver is ready, so three bytes yield four characters;
// a final byte that flushes padding yields up to four. The output register
// holds a single character at a time. A two-entry command queue lets the
// input side keep taking bytes while the result side stalls; when the queue
// and output register are idle, the first character of a byte passes through
// a queue entry and then the output register before it is offered.
`include "base64_stream_encoder_assert.svh"
module base64_stream_encoder import b64enc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  b64enc_in_if.sink    in_ch,
  b64enc_out_if.source out_ch
);

  b64enc_cmd_t   wr_cmd;
  b64enc_cmd_t   rd_cmd;
  b64enc_qstat_t qstat;
  logic          push;
  logic          pop;

  b64enc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.data_byte),
    .in_final (in_ch.is_final),
    .qstat    (qstat),
    .push     (push),
    .cmd      (wr_cmd)
  );

  b64enc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .qstat  (qstat)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rd_cmd),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .out_eor   (out_ch.end_of_run),
    .out_eom   (out_ch.end_of_message)
  );

  `B64_ASSERT_SAME(a_eom_ends_run, out_ch.valid && out_ch.end_of_message, out_ch.end_of_run)
  `B64_ASSERT_NEXT(a_no_char_from_nothing, qstat.empty && !out_ch.valid, !out_ch.valid)
  `B64_ASSERT_NEXT(a_transfer_queued, in_ch.valid && in_ch.ready, !qstat.empty)

endmodule

// File: rtl/b64enc_front.sv
// front end: accepts bytes, tracks group phase and leftover bits,
// builds a character command for the queue; depends on b64enc_pkg
module b64enc_front import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_final,
  input  b64enc_qstat_t qstat,
  output logic          push,
  output b64enc_cmd_t   cmd
);

  typedef enum logic [1:0] {
    PH_START,
    PH_SECOND,
    PH_THIRD
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    cmd.chars = {PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR};
    cmd.fin   = in_final;
    case (phase_r)
      PH_SECOND: begin
        cmd.chars[0] = b64_char({left_r[1:0], in_byte[7:4]});
        cmd.chars[1] = b64_char({in_byte[3:0], 2'b00});
        cmd.last_idx = in_final ? 2'd2 : 2'd0;
        phase_nxt    = PH_THIRD;
        left_nxt     = in_byte[3:0];
      end
      PH_THIRD: begin
        cmd.chars[0] = b64_char({left_r, in_byte[7:6]});
        cmd.chars[1] = b64_char(in_byte[5:0]);
        cmd.last_idx = 2'd1;
        phase_nxt    = PH_START;
        left_nxt     = 4'd0;
      end
      default: begin
        cmd.chars[0] = b64_char(in_byte[7:2]);
        cmd.chars[1] = b64_char({in_byte[1:0], 4'b0000});
        cmd.last_idx = in_final ? 2'd3 : 2'd0;
        phase_nxt    = PH_SECOND;
        left_nxt     = {2'b00, in_byte[1:0]};
      end
    endcase
    if (in_final) begin
      phase_nxt = PH_START;
      left_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      left_r  <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// File: rtl/b64enc_queue.sv
// two-entry command queue between front and back end
// depends on b64enc_pkg
module b64enc_queue import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  b64enc_cmd_t   wr_cmd,
  input  logic          pop,
  output b64enc_cmd_t   rd_cmd,
  output b64enc_qstat_t qstat
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  b64enc_cmd_t      entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign qstat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign rd_cmd      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/b64enc_back.sv
// back end: walks the head command one character per cycle, while the
// output is not stalled, into the output register; depends on b64enc_pkg
module b64enc_back import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  b64enc_cmd_t   cmd,
  input  b64enc_qstat_t qstat,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_eor,
  output logic          out_eom
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] char_r;
  logic       eor_r;
  logic       eom_r;
  logic       load;
  logic       last;

  assign load = !qstat.empty && (!valid_r || out_ready);
  assign last = (idx_r == cmd.last_idx);
  assign pop  = load && last;

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_eor   = eor_r;
  assign out_eom   = eom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= cmd.chars[idx_r];
      eor_r  <= last;
      eom_r  <= last && cmd.fin;
    end
  end

endmodule
